// ===== rtl/lfht_pkg.sv =====
// ----------------------------------------------------------------------------
// lfht_pkg
// Shared widths, operation and status codes, and controller/datapath structs
// for the lowest-free handle table.
// ----------------------------------------------------------------------------
package lfht_pkg;

  // Field widths of the command and result beats
  localparam int OP_W        = 2;
  localparam int ID_W        = 6;
  localparam int HANDLE_IO_W = 32;
  localparam int STATUS_W    = 2;

  // Ids a 6-bit field can name
  localparam int ID_SPACE = 64;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF     = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Occupancy search works on groups of this many slots
  localparam int GRP_SIZE = 8;
  localparam int GRP_IW   = 3;

  // Operation codes; the unused code acts as a lookup
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch the command beat
    logic find;        // register per-group free search
    logic pick;        // register lowest free id
    logic finish_ins;  // commit insert, load result
    logic finish_acc;  // commit lookup/remove, load result
  } lfht_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_insert;
  } lfht_stat_t;

endpackage

// ===== rtl/lfht_ram.sv =====
// ----------------------------------------------------------------------------
// lfht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lfht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfht_ctrl
// Sequencer for the handle table: accepts one command beat, steps the
// datapath through search or read, and strobes the result beat.
// ----------------------------------------------------------------------------
module lfht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lfht_pkg::lfht_stat_t stat,
  output lfht_pkg::lfht_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import lfht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_PICK,
    S_INSERT,
    S_ACCESS
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd.load       = start && (state == S_IDLE);
    cmd.find       = (state == S_FIND);
    cmd.pick       = (state == S_PICK);
    cmd.finish_ins = (state == S_INSERT);
    cmd.finish_acc = (state == S_ACCESS);
  end

  assign busy = (state != S_IDLE);

  // Advance state and register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_INSERT) || (state == S_ACCESS);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_FIND;
          end
        end
        // Group search and RAM read run side by side here
        S_FIND: begin
          if (stat.is_insert) begin
            state <= S_PICK;
          end else begin
            state <= S_ACCESS;
          end
        end
        S_PICK:   state <= S_INSERT;
        S_INSERT: state <= S_IDLE;
        S_ACCESS: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lfht_datapath.sv =====
// ----------------------------------------------------------------------------
// lfht_datapath
// Command latch, occupancy mask, two-level lowest-free search, handle RAM
// and result registers of the handle table.
// ----------------------------------------------------------------------------
module lfht_datapath #(
  parameter int CAPACITY     = lfht_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = lfht_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lfht_pkg::lfht_cmd_t                 cmd,
  output lfht_pkg::lfht_stat_t                stat,
  input  logic [lfht_pkg::OP_W-1:0]           operation,
  input  logic [lfht_pkg::ID_W-1:0]           slot_id,
  input  logic [lfht_pkg::HANDLE_IO_W-1:0]    handle_in,
  output logic [lfht_pkg::ID_W-1:0]           assigned_id,
  output logic [lfht_pkg::HANDLE_IO_W-1:0]    handle_out,
  output logic [lfht_pkg::STATUS_W-1:0]       status
);
  import lfht_pkg::*;

  localparam int USABLE = (CAPACITY < ID_SPACE) ? CAPACITY : ID_SPACE;
  localparam int AW     = $clog2(USABLE);
  localparam int NGRP   = (USABLE + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PADW   = NGRP * GRP_SIZE;

  // Latched command beat
  logic [OP_W-1:0]         op_q;
  logic [ID_W-1:0]         id_q;
  logic [HANDLE_WIDTH-1:0] hnd_q;
  logic [HANDLE_WIDTH-1:0] hnd_c;

  // Occupancy and search state
  logic [USABLE-1:0]       mask;
  logic [PADW-1:0]         pmask;
  logic [NGRP-1:0]         grp_free;
  logic [NGRP-1:0]         grp_free_c;
  logic [GRP_IW-1:0]       grp_idx   [NGRP];
  logic [GRP_IW-1:0]       grp_idx_c [NGRP];
  logic                    found_q;
  logic                    found_c;
  logic [ID_W-1:0]         free_id_q;
  logic [ID_W-1:0]         free_id_c;

  // Access path
  logic                    in_range;
  logic                    occ;
  logic                    ram_we;
  logic [HANDLE_WIDTH-1:0] rdata;
  logic [HANDLE_IO_W-1:0]  rd_io;

  // Fit the handle to the storage width and back to the port width
  if (HANDLE_WIDTH > HANDLE_IO_W) begin : g_wide
    assign hnd_c = {{(HANDLE_WIDTH - HANDLE_IO_W){1'b0}}, handle_in};
    assign rd_io = rdata[HANDLE_IO_W-1:0];
  end else if (HANDLE_WIDTH == HANDLE_IO_W) begin : g_equal
    assign hnd_c = handle_in;
    assign rd_io = rdata;
  end else begin : g_narrow
    assign hnd_c = handle_in[HANDLE_WIDTH-1:0];
    assign rd_io = {{(HANDLE_IO_W - HANDLE_WIDTH){1'b0}}, rdata};
  end

  assign stat.is_insert = (op_q == OP_INSERT);

  // Pad the mask so slots past the end look occupied
  always_comb begin
    pmask             = '1;
    pmask[USABLE-1:0] = mask;
  end

  // Find the lowest free slot inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_c[g] = 1'b0;
      grp_idx_c[g]  = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!pmask[g*GRP_SIZE + b]) begin
          grp_free_c[g] = 1'b1;
          grp_idx_c[g]  = GRP_IW'(b);
        end
      end
    end
  end

  // Pick the lowest group that has a free slot
  always_comb begin
    found_c   = 1'b0;
    free_id_c = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        found_c   = 1'b1;
        free_id_c = ID_W'(g * GRP_SIZE) | ID_W'(grp_idx[g]);
      end
    end
  end

  // Occupancy of the addressed slot
  assign in_range = ({1'b0, id_q} < (ID_W+1)'(USABLE));
  assign occ      = in_range && mask[id_q[AW-1:0]];
  assign ram_we   = cmd.finish_ins && found_q;

  lfht_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (USABLE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_id_q[AW-1:0]),
    .wdata (hnd_q),
    .raddr (id_q[AW-1:0]),
    .rdata (rdata)
  );

  // Latch the beat and register search stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      id_q  <= slot_id;
      hnd_q <= hnd_c;
    end
    if (cmd.find) begin
      grp_free <= grp_free_c;
      grp_idx  <= grp_idx_c;
    end
    if (cmd.pick) begin
      found_q   <= found_c;
      free_id_q <= free_id_c;
    end
  end

  // Update occupancy; a zero handle leaves its slot free
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (ram_we) begin
      mask[free_id_q[AW-1:0]] <= (hnd_q != '0);
    end else if (cmd.finish_acc && occ && (op_q == OP_REMOVE)) begin
      mask[id_q[AW-1:0]] <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.finish_ins) begin
      handle_out <= '0;
      if (found_q) begin
        assigned_id <= free_id_q;
        status      <= STATUS_OK;
      end else begin
        assigned_id <= '0;
        status      <= STATUS_FULL;
      end
    end else if (cmd.finish_acc) begin
      assigned_id <= id_q;
      handle_out  <= occ ? rd_io : '0;
      status      <= occ ? STATUS_OK : STATUS_EMPTY;
    end
  end

endmodule

// ===== rtl/lowest_free_handle_table.sv =====
// ----------------------------------------------------------------------------
// lowest_free_handle_table
// Handle table over small ids: insert into the lowest free slot, look up
// an id, or remove an id and return the handle it held.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                   | beat taken when
//   ---------+-----------------------------------------+------------------
//   command  | operation, slot_id, handle_in           | start && !busy
//   result   | assigned_id, handle_out, status         | done (one cycle)
//
// One command at a time. An insert steps through group search, lowest-group
// pick and write before it raises done; lookup and remove raise it after the
// registered handle RAM read. busy drops in the cycle done is high, so the
// next command can be taken while the result is shown.
// rst is synchronous; it clears the occupancy mask, so every slot reads as
// empty at once with no clearing pass. The receiver cannot stall results.
//
module lowest_free_handle_table #(
  parameter int CAPACITY     = lfht_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = lfht_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lfht_pkg::OP_W-1:0]        operation,
  input  logic [lfht_pkg::ID_W-1:0]        slot_id,
  input  logic [lfht_pkg::HANDLE_IO_W-1:0] handle_in,
  output logic                             busy,
  output logic                             done,
  output logic [lfht_pkg::ID_W-1:0]        assigned_id,
  output logic [lfht_pkg::HANDLE_IO_W-1:0] handle_out,
  output logic [lfht_pkg::STATUS_W-1:0]    status
);
  import lfht_pkg::*;

  lfht_cmd_t  cmd;
  lfht_stat_t stat;

  lfht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lfht_datapath #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .slot_id     (slot_id),
    .handle_in   (handle_in),
    .assigned_id (assigned_id),
    .handle_out  (handle_out),
    .status      (status)
  );

endmodule

// ===== rtl/lfht_checker.sv =====
// ----------------------------------------------------------------------------
// lfht_checker
// Port-level checks of the handle table's command and result beats.
// ----------------------------------------------------------------------------
module lfht_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [lfht_pkg::ID_W-1:0]        assigned_id,
  input logic [lfht_pkg::HANDLE_IO_W-1:0] handle_out,
  input logic [lfht_pkg::STATUS_W-1:0]    status
);
  import lfht_pkg::*;

  // An accepted beat makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command beat");

  // The result strobe shows only once the command has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // A full report carries id zero and no handle
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL)) |-> ((assigned_id == '0) && (handle_out == '0)))
    else $error("full result with nonzero id or handle");

  // An empty slot returns no handle
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_EMPTY)) |-> (handle_out == '0))
    else $error("empty-slot result with nonzero handle");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == STATUS_OK) || (status == STATUS_FULL) || (status == STATUS_EMPTY)))
    else $error("undefined status code on result beat");

endmodule

bind lowest_free_handle_table lfht_checker u_lfht_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .assigned_id (assigned_id),
  .handle_out  (handle_out),
  .status      (status)
);

// ===== tb/sv/lowest_free_handle_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_handle_table_test
// Self-checking bench for the handle table. A queue of command beats (a short
// directed opening, then insert-heavy and remove-heavy rounds of random
// traffic) feeds a bursty driver. A scoreboard mirrors the table contents and
// its occupancy, predicts every result at the accepting edge, and a monitor
// checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module lowest_free_handle_table_test;
  import lfht_pkg::*;

  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // Spare operation code; the block treats it as a lookup
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [ID_W-1:0]        id;
    logic [HANDLE_IO_W-1:0] handle;
  } table_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [HANDLE_IO_W-1:0] handle;
    logic [STATUS_W-1:0]    status;
  } table_rsp_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic [OP_W-1:0]        operation = OP_INSERT;
  logic [ID_W-1:0]        slot_id   = '0;
  logic [HANDLE_IO_W-1:0] handle_in = '0;
  logic                   busy;
  logic                   done;
  logic [ID_W-1:0]        assigned_id;
  logic [HANDLE_IO_W-1:0] handle_out;
  logic [STATUS_W-1:0]    status;

  // Mirror of the table: stored handles and occupancy bits
  logic [HANDLE_IO_W-1:0] mirror_handles [SLOTS];
  logic [SLOTS-1:0]       mirror_occupied = '0;

  table_cmd_t command_q [$];
  table_rsp_t predicted_q [$];
  table_cmd_t driven_cmd;
  int         total_items    = 0;
  int         accepted_items = 0;
  int         fail_count     = 0;
  int         burst_left     = 1;
  int         gap_left       = 0;

  lowest_free_handle_table u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .slot_id     (slot_id),
    .handle_in   (handle_in),
    .busy        (busy),
    .done        (done),
    .assigned_id (assigned_id),
    .handle_out  (handle_out),
    .status      (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the mirror and return the result it should give
  function automatic table_rsp_t apply_to_mirror(table_cmd_t c);
    table_rsp_t r;
    int         slot;
    bit         found;
    r.id     = c.id;
    r.handle = '0;
    r.status = STATUS_OK;
    slot     = 0;
    found    = 1'b0;
    if (c.op == OP_INSERT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !mirror_occupied[i]) begin
          found = 1'b1;
          slot  = i;
        end
      end
      if (found) begin
        // a zero handle takes the slot but leaves it free
        mirror_handles[slot]  = c.handle;
        mirror_occupied[slot] = (c.handle != '0);
        r.id = slot[ID_W-1:0];
      end else begin
        r.id     = '0;
        r.status = STATUS_FULL;
      end
    end else if (mirror_occupied[c.id]) begin
      r.handle = mirror_handles[c.id];
      if (c.op == OP_REMOVE) begin
        mirror_handles[c.id]  = '0;
        mirror_occupied[c.id] = 1'b0;
      end
    end else begin
      r.status = STATUS_EMPTY;
    end
    return r;
  endfunction

  task automatic queue_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [HANDLE_IO_W-1:0] h);
    table_cmd_t c;
    c.op     = op;
    c.id     = id;
    c.handle = h;
    command_q.push_back(c);
    total_items++;
  endtask

  // Favor low ids, where inserts land first
  function automatic logic [ID_W-1:0] pick_slot();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return ID_W'($urandom_range(0, 7));
    if (sel < 6) return ID_W'($urandom_range(0, 31));
    return ID_W'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic logic [HANDLE_IO_W-1:0] pick_handle();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return 32'h1 << $urandom_range(0, HANDLE_IO_W - 1);
    return $urandom;
  endfunction

  // Drive command beats in bursts; hold a beat while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_q.push_back(apply_to_mirror(driven_cmd));
        accepted_items++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (command_q.size() > 0) begin
          driven_cmd = command_q.pop_front();
          operation <= driven_cmd.op;
          slot_id   <= driven_cmd.id;
          handle_in <= driven_cmd.handle;
          start     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    table_rsp_t got;
    table_rsp_t want;
    if (!rst && done) begin
      got.id     = assigned_id;
      got.handle = handle_out;
      got.status = status;
      if (predicted_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: id=%0d handle=%h status=%0d",
                   got.id, got.handle, got.status);
      end else begin
        want = predicted_q.pop_front();
        if (got.id !== want.id || got.handle !== want.handle ||
            got.status !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"mismatch: expected id=%0d handle=%h status=%0d, ",
                      "got id=%0d handle=%h status=%0d"},
                     want.id, want.handle, want.status,
                     got.id, got.handle, got.status);
        end
      end
    end
  end

  // Build stimulus, release reset, wait for the drain, report
  initial begin
    int round_left;
    int insert_pct;
    int sel;
    for (int i = 0; i < SLOTS; i++) mirror_handles[i] = '0;

    // directed opening: extremes, zero-handle insert, empty slots, spare code
    queue_cmd(OP_INSERT, 6'd63, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 6'd0,  32'h0000_0001);
    queue_cmd(OP_INSERT, 6'd5,  32'h0000_0000);
    queue_cmd(OP_INSERT, 6'd0,  32'h8000_0000);
    queue_cmd(OP_LOOKUP, 6'd0,  32'hFFFF_FFFF);
    queue_cmd(OP_LOOKUP, 6'd1,  32'h0);
    queue_cmd(OP_LOOKUP, 6'd63, 32'h0);
    queue_cmd(OP_SPARE,  6'd2,  32'h0);
    queue_cmd(OP_SPARE,  6'd40, 32'h0);
    queue_cmd(OP_REMOVE, 6'd1,  32'h0);
    queue_cmd(OP_REMOVE, 6'd1,  32'h0);
    queue_cmd(OP_LOOKUP, 6'd1,  32'h0);
    queue_cmd(OP_INSERT, 6'd63, 32'hA5A5_A5A5);
    queue_cmd(OP_REMOVE, 6'd0,  32'h0);
    queue_cmd(OP_LOOKUP, 6'd0,  32'h0);
    queue_cmd(OP_INSERT, 6'd21, 32'h5A5A_5A5A);
    queue_cmd(OP_REMOVE, 6'd63, 32'h0);
    queue_cmd(OP_REMOVE, 6'd2,  32'h0);
    queue_cmd(OP_INSERT, 6'd0,  32'h7FFF_FFFF);

    // random rounds; the first fills the table well past full
    round_left = 100;
    insert_pct = 92;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (round_left == 0) begin
        sel        = $urandom_range(0, 2);
        insert_pct = (sel == 0) ? 85 : (sel == 1) ? 50 : 20;
        round_left = $urandom_range(40, 120);
      end
      round_left--;
      if ($urandom_range(0, 99) < insert_pct) begin
        queue_cmd(OP_INSERT, ID_W'($urandom_range(0, SLOTS - 1)), pick_handle());
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 50)
          queue_cmd(OP_REMOVE, pick_slot(), $urandom);
        else if (sel < 92)
          queue_cmd(OP_LOOKUP, pick_slot(), $urandom);
        else
          queue_cmd(OP_SPARE, pick_slot(), $urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items < total_items || predicted_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && predicted_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
